### hdl/dptf_pkg.sv
// ----------------------------------------------------------------------------
// dptf_pkg: shared types and constants
// Status codes, register indexes and control state types for the device
// position to timeline frame converter.
// ----------------------------------------------------------------------------
package dptf_pkg;

    // Result status codes.
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_RATE   = 3'd1;
    localparam logic [2:0] ST_BAD_FREQ   = 3'd2;
    localparam logic [2:0] ST_BAD_ANCHOR = 3'd3;
    localparam logic [2:0] ST_STALE      = 3'd4;
    localparam logic [2:0] ST_BACKWARDS  = 3'd5;
    localparam logic [2:0] ST_OVERFLOW   = 3'd6;

    // Configuration register indexes.
    localparam logic [2:0] REG_ANCHOR_POSITION   = 3'd0;
    localparam logic [2:0] REG_ANCHOR_FRAME      = 3'd1;
    localparam logic [2:0] REG_CLOCK_FREQUENCY   = 3'd2;
    localparam logic [2:0] REG_ANCHOR_GENERATION = 3'd3;
    localparam logic [2:0] REG_RATE_NUMERATOR    = 3'd4;
    localparam logic [2:0] REG_RATE_DENOMINATOR  = 3'd5;

    // Serial divider: start request and finished status.
    typedef struct packed {
        logic start;
        logic wide;     // 128 by 64 division when set, else 64 by 64
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Serial multiplier handshake.
    typedef struct packed {
        logic start;
    } mul_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_GCD_SETUP,
        S_GCD_DIV,
        S_GCD_WAIT,
        S_RED_A,
        S_RED_A_WAIT,
        S_RED_B,
        S_RED_B_WAIT,
        S_NEXT_STEP,
        S_DEN_MUL,
        S_DEN_WAIT,
        S_PROD_MUL,
        S_PROD_WAIT,
        S_QUOT_DIV,
        S_QUOT_WAIT,
        S_SUM,
        S_OUT
    } seq_state_t;

endpackage

### hdl/dptf_divider.sv
// ----------------------------------------------------------------------------
// dptf_divider: bit-serial restoring divider
// Divides a 128-bit dividend (high half below the divisor) or a 64-bit
// dividend by a 64-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dptf_divider (
    input  logic                clk,
    input  logic                rst_n,
    input  dptf_pkg::div_ctrl_t ctrl,
    input  logic [63:0]         dividend_hi,
    input  logic [63:0]         dividend_lo,
    input  logic [63:0]         divisor,
    output dptf_pkg::div_stat_t stat,
    output logic [63:0]         quotient,
    output logic [63:0]         remainder
);

    logic [63:0] rem_reg, rem_next;
    logic [63:0] low_reg, low_next;
    logic [63:0] dsr_reg, dsr_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    logic [64:0] shifted;
    logic        take;

    // One restoring step: shift in the next dividend bit and trial subtract.
    assign shifted = {rem_reg, low_reg[63]};
    assign take    = shifted >= {1'b0, dsr_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start)
        begin
            rem_next  = ctrl.wide ? dividend_hi : 64'd0;
            low_next  = dividend_lo;
            dsr_next  = divisor;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = take ? 64'(shifted - {1'b0, dsr_reg}) : shifted[63:0];
            low_next = {low_reg[62:0], take};
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        dsr_reg <= dsr_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = low_reg;
    assign remainder = rem_reg;

    // The count only runs while busy.
    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg && !ctrl.start |=> cnt_reg == $past(cnt_reg))
        else $error("divider count moved while idle");
    // Done follows the last step only.
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");
    a_rem: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !ctrl.start && cnt_reg != 7'd64 |-> rem_reg < dsr_reg)
        else $error("partial remainder not below divisor");

endmodule

### hdl/dptf_multiplier.sv
// ----------------------------------------------------------------------------
// dptf_multiplier: bit-serial shift and add multiplier
// Forms the exact 128-bit product of two 64-bit operands, one multiplier
// bit per cycle.
// ----------------------------------------------------------------------------
module dptf_multiplier (
    input  logic                clk,
    input  logic                rst_n,
    input  dptf_pkg::mul_ctrl_t ctrl,
    input  logic [63:0]         op_a,
    input  logic [63:0]         op_b,
    output dptf_pkg::mul_stat_t stat,
    output logic [127:0]        product
);

    logic [63:0] acc_reg, acc_next;   // high half of the running product
    logic [63:0] mpr_reg, mpr_next;   // multiplier bits, low half fills in
    logic [63:0] mcd_reg, mcd_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    logic [64:0] sum;

    // Add the multiplicand when the current bit is set, then shift right.
    assign sum = {1'b0, acc_reg} + (mpr_reg[0] ? {1'b0, mcd_reg} : 65'd0);

    always_comb
    begin
        acc_next  = acc_reg;
        mpr_next  = mpr_reg;
        mcd_next  = mcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start)
        begin
            acc_next  = 64'd0;
            mpr_next  = op_b;
            mcd_next  = op_a;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = sum[64:1];
            mpr_next = {sum[0], mpr_reg[63:1]};
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mpr_reg <= mpr_next;
        mcd_reg <= mcd_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign product   = {acc_reg, mpr_reg};

    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("multiplier done without a run");
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg != 7'd0)
        else $error("multiplier busy with empty count");
    a_mcd: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !$past(ctrl.start) && $past(busy_reg) |-> $stable(mcd_reg))
        else $error("multiplicand changed during a run");

endmodule

### hdl/device_position_to_timeline_frame.sv
// ----------------------------------------------------------------------------
// device_position_to_timeline_frame: device position to timeline frame
// Validates a sampled device position against the anchor, reduces the
// ratio terms by four gcd steps and forms the elapsed frames with a serial
// multiplier and divider.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                                       Direction
//   config    cfg_write, cfg_index, cfg_data                in
//   input     in_valid, in_stall, sample_position, sample_generation
//   output    out_valid, out_stall, frame_number, status
//
// One request at a time, accepted only when idle. A request that fails a check
// in S_CHECK goes from S_CHECK straight to S_OUT; the next request can be
// accepted in the cycle after the result is taken. A full request runs eight
// reductions, two multiplies and one 128 by 64 division, with sequencing
// states between them, plus one divider run for each gcd remainder step. A
// 64-bit gcd needs up to about 93 remainder steps.
// Reset clears the control state and loads the register reset values.
// in_stall is high from acceptance until the result has been taken; the
// result waits in its register while out_stall is high.
// ----------------------------------------------------------------------------
module device_position_to_timeline_frame (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] sample_position,
    input  logic [31:0] sample_generation,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [62:0] frame_number,
    output logic [2:0]  status
);

    // Configuration registers.
    logic [63:0] anchor_position_reg;
    logic [63:0] anchor_frame_reg;
    logic [63:0] clock_frequency_reg;
    logic [31:0] anchor_generation_reg;
    logic [31:0] rate_numerator_reg;
    logic [31:0] rate_denominator_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            anchor_position_reg   <= 64'd0;
            anchor_frame_reg      <= 64'd0;
            clock_frequency_reg   <= 64'd48000;
            anchor_generation_reg <= 32'd0;
            rate_numerator_reg    <= 32'd30;
            rate_denominator_reg  <= 32'd1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                dptf_pkg::REG_ANCHOR_POSITION:   anchor_position_reg   <= cfg_data;
                dptf_pkg::REG_ANCHOR_FRAME:      anchor_frame_reg      <= cfg_data;
                dptf_pkg::REG_CLOCK_FREQUENCY:   clock_frequency_reg   <= cfg_data;
                dptf_pkg::REG_ANCHOR_GENERATION: anchor_generation_reg <= cfg_data[31:0];
                dptf_pkg::REG_RATE_NUMERATOR:    rate_numerator_reg    <= cfg_data[31:0];
                dptf_pkg::REG_RATE_DENOMINATOR:  rate_denominator_reg  <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    dptf_pkg::seq_state_t state_reg, state_next;

    // Working values.
    logic [63:0] pos_reg, pos_next;
    logic [31:0] gen_reg, gen_next;
    logic [63:0] delta_reg, delta_next;
    logic [63:0] num_reg, num_next;
    logic [63:0] freq_reg, freq_next;
    logic [63:0] den_reg, den_next;
    logic [63:0] ga_reg, ga_next;     // gcd operands
    logic [63:0] gb_reg, gb_next;
    logic [1:0]  step_reg, step_next;
    logic [63:0] elapsed_reg, elapsed_next;
    logic [62:0] frame_reg, frame_next;
    logic [2:0]  status_reg, status_next;

    // Shared serial units.
    dptf_pkg::div_ctrl_t div_ctrl;
    dptf_pkg::div_stat_t div_stat;
    dptf_pkg::mul_ctrl_t mul_ctrl;
    dptf_pkg::mul_stat_t mul_stat;
    logic [63:0]  div_hi, div_lo, div_dsr, div_q, div_r;
    logic [63:0]  mul_a, mul_b;
    logic [127:0] mul_p;

    dptf_divider u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (div_ctrl),
        .dividend_hi (div_hi),
        .dividend_lo (div_lo),
        .divisor     (div_dsr),
        .stat        (div_stat),
        .quotient    (div_q),
        .remainder   (div_r)
    );

    dptf_multiplier u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (mul_ctrl),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .stat    (mul_stat),
        .product (mul_p)
    );

    // Operand pair of the current gcd step: first, second.
    logic [63:0] pair_a, pair_b;
    always_comb
    begin
        unique case (step_reg)
            2'd0: begin pair_a = delta_reg; pair_b = freq_reg; end
            2'd1: begin pair_a = delta_reg; pair_b = den_reg;  end
            2'd2: begin pair_a = num_reg;   pair_b = freq_reg; end
            default: begin pair_a = num_reg; pair_b = den_reg; end
        endcase
    end

    logic [64:0] sum_wide;
    assign sum_wide = {1'b0, anchor_frame_reg} + {1'b0, elapsed_reg};

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dptf_pkg::S_IDLE:       if (in_valid) state_next = dptf_pkg::S_CHECK;
            dptf_pkg::S_CHECK:
                if (status_next != dptf_pkg::ST_OK) state_next = dptf_pkg::S_OUT;
                else state_next = dptf_pkg::S_GCD_SETUP;
            dptf_pkg::S_GCD_SETUP:  state_next = dptf_pkg::S_GCD_DIV;
            dptf_pkg::S_GCD_DIV:
                state_next = (gb_reg == 64'd0) ? dptf_pkg::S_RED_A : dptf_pkg::S_GCD_WAIT;
            dptf_pkg::S_GCD_WAIT:   if (div_stat.done) state_next = dptf_pkg::S_GCD_DIV;
            dptf_pkg::S_RED_A:      state_next = dptf_pkg::S_RED_A_WAIT;
            dptf_pkg::S_RED_A_WAIT: if (div_stat.done) state_next = dptf_pkg::S_RED_B;
            dptf_pkg::S_RED_B:      state_next = dptf_pkg::S_RED_B_WAIT;
            dptf_pkg::S_RED_B_WAIT: if (div_stat.done) state_next = dptf_pkg::S_NEXT_STEP;
            dptf_pkg::S_NEXT_STEP:
                state_next = (step_reg == 2'd3) ? dptf_pkg::S_DEN_MUL : dptf_pkg::S_GCD_SETUP;
            dptf_pkg::S_DEN_MUL:    state_next = dptf_pkg::S_DEN_WAIT;
            dptf_pkg::S_DEN_WAIT:
                if (mul_stat.done)
                    state_next = (mul_p[127:64] != 64'd0) ? dptf_pkg::S_OUT
                                                          : dptf_pkg::S_PROD_MUL;
            dptf_pkg::S_PROD_MUL:   state_next = dptf_pkg::S_PROD_WAIT;
            dptf_pkg::S_PROD_WAIT:
                if (mul_stat.done)
                    state_next = (mul_p[127:64] >= den_reg) ? dptf_pkg::S_OUT
                                                            : dptf_pkg::S_QUOT_DIV;
            dptf_pkg::S_QUOT_DIV:   state_next = dptf_pkg::S_QUOT_WAIT;
            dptf_pkg::S_QUOT_WAIT:  if (div_stat.done) state_next = dptf_pkg::S_SUM;
            dptf_pkg::S_SUM:        state_next = dptf_pkg::S_OUT;
            dptf_pkg::S_OUT:        if (!out_stall) state_next = dptf_pkg::S_IDLE;
            default:                state_next = dptf_pkg::S_IDLE;
        endcase
    end

    // Datapath and unit control. After the divisor multiply den_reg holds
    // freq*den; the product is kept in ga_reg:gb_reg.
    always_comb
    begin
        pos_next     = pos_reg;
        gen_next     = gen_reg;
        delta_next   = delta_reg;
        num_next     = num_reg;
        freq_next    = freq_reg;
        den_next     = den_reg;
        ga_next      = ga_reg;
        gb_next      = gb_reg;
        step_next    = step_reg;
        elapsed_next = elapsed_reg;
        frame_next   = frame_reg;
        status_next  = status_reg;
        div_ctrl     = '0;
        mul_ctrl     = '0;
        div_hi       = ga_reg;
        div_lo       = gb_reg;
        div_dsr      = den_reg;
        mul_a        = freq_reg;
        mul_b        = den_reg;
        unique case (state_reg)
            dptf_pkg::S_IDLE:
            begin
                pos_next = sample_position;
                gen_next = sample_generation;
            end
            dptf_pkg::S_CHECK:
            begin
                frame_next = 63'd0;
                priority if (rate_numerator_reg == 32'd0 || rate_denominator_reg == 32'd0)
                    status_next = dptf_pkg::ST_BAD_RATE;
                else if (clock_frequency_reg == 64'd0)
                    status_next = dptf_pkg::ST_BAD_FREQ;
                else if (anchor_frame_reg[63])
                    status_next = dptf_pkg::ST_BAD_ANCHOR;
                else if (gen_reg != anchor_generation_reg)
                    status_next = dptf_pkg::ST_STALE;
                else if (pos_reg < anchor_position_reg)
                    status_next = dptf_pkg::ST_BACKWARDS;
                else
                    status_next = dptf_pkg::ST_OK;
                delta_next = pos_reg - anchor_position_reg;
                num_next   = {32'd0, rate_numerator_reg};
                freq_next  = clock_frequency_reg;
                den_next   = {32'd0, rate_denominator_reg};
                step_next  = 2'd0;
            end
            dptf_pkg::S_GCD_SETUP:
            begin
                ga_next = pair_a;
                gb_next = pair_b;
            end
            dptf_pkg::S_GCD_DIV:
            begin
                // Remainder step a mod b; when b is zero ga holds the gcd.
                div_ctrl.start = (gb_reg != 64'd0);
                div_hi         = 64'd0;
                div_lo         = ga_reg;
                div_dsr        = gb_reg;
            end
            dptf_pkg::S_GCD_WAIT:
                if (div_stat.done)
                begin
                    ga_next = gb_reg;
                    gb_next = div_r;
                end
            dptf_pkg::S_RED_A:
            begin
                div_ctrl.start = 1'b1;
                div_hi         = 64'd0;
                div_lo         = pair_a;
                div_dsr        = ga_reg;
            end
            dptf_pkg::S_RED_A_WAIT:
                if (div_stat.done)
                begin
                    if (step_reg[1]) num_next = div_q;
                    else delta_next = div_q;
                end
            dptf_pkg::S_RED_B:
            begin
                div_ctrl.start = 1'b1;
                div_hi         = 64'd0;
                div_lo         = pair_b;
                div_dsr        = ga_reg;
            end
            dptf_pkg::S_RED_B_WAIT:
                if (div_stat.done)
                begin
                    if (step_reg[0]) den_next = div_q;
                    else freq_next = div_q;
                end
            dptf_pkg::S_NEXT_STEP:
                step_next = step_reg + 2'd1;
            dptf_pkg::S_DEN_MUL:
                mul_ctrl.start = 1'b1;
            dptf_pkg::S_DEN_WAIT:
                if (mul_stat.done)
                begin
                    den_next = mul_p[63:0];
                    if (mul_p[127:64] != 64'd0) status_next = dptf_pkg::ST_OVERFLOW;
                end
            dptf_pkg::S_PROD_MUL:
            begin
                mul_ctrl.start = 1'b1;
                mul_a          = delta_reg;
                mul_b          = num_reg;
            end
            dptf_pkg::S_PROD_WAIT:
                if (mul_stat.done)
                begin
                    ga_next = mul_p[127:64];
                    gb_next = mul_p[63:0];
                    if (mul_p[127:64] >= den_reg) status_next = dptf_pkg::ST_OVERFLOW;
                end
            dptf_pkg::S_QUOT_DIV:
            begin
                div_ctrl.start = 1'b1;
                div_ctrl.wide  = 1'b1;
            end
            dptf_pkg::S_QUOT_WAIT:
                if (div_stat.done) elapsed_next = div_q;
            dptf_pkg::S_SUM:
                if (sum_wide[64:63] != 2'd0) status_next = dptf_pkg::ST_OVERFLOW;
                else frame_next = sum_wide[62:0];
            dptf_pkg::S_OUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dptf_pkg::S_IDLE;
            step_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        gen_reg     <= gen_next;
        delta_reg   <= delta_next;
        num_reg     <= num_next;
        freq_reg    <= freq_next;
        den_reg     <= den_next;
        ga_reg      <= ga_next;
        gb_reg      <= gb_next;
        elapsed_reg <= elapsed_next;
        frame_reg   <= frame_next;
        status_reg  <= status_next;
    end

    // Handshake outputs.
    always_comb
    begin
        in_stall     = (state_reg != dptf_pkg::S_IDLE);
        out_valid    = (state_reg == dptf_pkg::S_OUT);
        frame_number = frame_reg;
        status       = status_reg;
    end

    // A result leaves only with a zero frame when the status is not ok.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != dptf_pkg::ST_OK |-> frame_number == 63'd0)
        else $error("failed result carries a frame");
    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(frame_number))
        else $error("stalled result changed");
    // The units never start while busy.
    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_ctrl.start |-> !div_stat.busy)
        else $error("divider restarted while busy");
    a_mul_start: assert property (@(posedge clk) disable iff (!rst_n)
        mul_ctrl.start |-> !mul_stat.busy)
        else $error("multiplier restarted while busy");

endmodule

### sim/device_position_to_timeline_frame_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// device_position_to_timeline_frame_tb: self-checking bench for the converter
// Walks a table of directed requests covering every status code and the
// register extremes, then runs phases of random anchors and samples under
// several sender and receiver idling patterns. Each result is compared with
// its row's typed result or else with a predictor computed in the bench.
// ----------------------------------------------------------------------------
module device_position_to_timeline_frame_tb;

    localparam int unsigned CYCLE_LIMIT = 150_000_000;
    localparam logic [63:0] U64_MAX     = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] FRAME_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] FRAME_MIN   = 64'h8000_0000_0000_0000;
    localparam logic [31:0] U32_MAX     = 32'hFFFF_FFFF;
    // Indexes beyond the register file; writes to them must be ignored.
    localparam logic [2:0]  REG_SPARE_LO = 3'd6;
    localparam logic [2:0]  REG_SPARE_HI = 3'd7;
    localparam int          N_PHASES     = 20;

    typedef struct packed {
        logic [62:0] frame;
        logic [2:0]  code;
    } frame_result_t;

    // One directed request with the anchor and rate it runs under.
    typedef struct packed {
        logic [63:0] anchor_pos;
        logic [63:0] anchor_frm;
        logic [63:0] freq;
        logic [31:0] anchor_gen;
        logic [31:0] num;
        logic [31:0] den;
        logic [63:0] pos;
        logic [31:0] gen;
        logic        typed;
        logic [62:0] frame;
        logic [2:0]  code;
    } directed_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [63:0] sample_position;
    logic [31:0] sample_generation;
    logic        out_valid;
    logic        out_stall;
    logic [62:0] frame_number;
    logic [2:0]  status;

    // Bench copy of the configuration registers.
    logic [63:0] anchor_pos_q;
    logic [63:0] anchor_frm_q;
    logic [63:0] freq_q;
    logic [31:0] anchor_gen_q;
    logic [31:0] num_q;
    logic [31:0] den_q;

    frame_result_t expected_frames[$];
    directed_row_t directed_rows[$];
    int unsigned   sender_idle_pct;
    int unsigned   receiver_stall_pct;
    int unsigned   mismatches;
    int unsigned   requests_sent;
    int unsigned   results_seen;
    int unsigned   code_hits[8];
    int unsigned   cycles;

    device_position_to_timeline_frame uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .sample_position   (sample_position),
        .sample_generation (sample_generation),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .frame_number      (frame_number),
        .status            (status)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Euclid on 64-bit operands.
    function automatic logic [63:0] gcd_u64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] t;
        while (b != 64'd0)
        begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    // Predicts the frame and status for one sample under the current anchor.
    function automatic frame_result_t calc_timeline_frame(input logic [63:0] pos,
                                                          input logic [31:0] gen);
        frame_result_t r;
        logic [63:0]   delta, num, freq, den, g, divisor, elapsed;
        logic [127:0]  wide_div, prod, quot;
        r.frame = '0;
        r.code  = dptf_pkg::ST_OK;
        if (num_q == 32'd0 || den_q == 32'd0)
            r.code = dptf_pkg::ST_BAD_RATE;
        else if (freq_q == 64'd0)
            r.code = dptf_pkg::ST_BAD_FREQ;
        else if (anchor_frm_q[63])
            r.code = dptf_pkg::ST_BAD_ANCHOR;
        else if (gen != anchor_gen_q)
            r.code = dptf_pkg::ST_STALE;
        else if (pos < anchor_pos_q)
            r.code = dptf_pkg::ST_BACKWARDS;
        if (r.code == dptf_pkg::ST_OK)
        begin
            delta = pos - anchor_pos_q;
            num   = {32'd0, num_q};
            freq  = freq_q;
            den   = {32'd0, den_q};
            g = gcd_u64(delta, freq); delta = delta / g; freq = freq / g;
            g = gcd_u64(delta, den);  delta = delta / g; den = den / g;
            g = gcd_u64(num, freq);   num = num / g;     freq = freq / g;
            g = gcd_u64(num, den);    num = num / g;     den = den / g;
            wide_div = {64'd0, freq} * {64'd0, den};
            prod     = {64'd0, delta} * {64'd0, num};
            divisor  = wide_div[63:0];
            if (wide_div[127:64] != 64'd0 || prod[127:64] >= divisor)
                r.code = dptf_pkg::ST_OVERFLOW;
            else
            begin
                quot    = prod / {64'd0, divisor};
                elapsed = quot[63:0];
                if (elapsed > FRAME_MAX - anchor_frm_q)
                    r.code = dptf_pkg::ST_OVERFLOW;
                else
                    r.frame = anchor_frm_q[62:0] + elapsed[62:0];
            end
        end
        return r;
    endfunction

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Single register write; the bench copy follows the block.
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            dptf_pkg::REG_ANCHOR_POSITION:   anchor_pos_q = value;
            dptf_pkg::REG_ANCHOR_FRAME:      anchor_frm_q = value;
            dptf_pkg::REG_CLOCK_FREQUENCY:   freq_q       = value;
            dptf_pkg::REG_ANCHOR_GENERATION: anchor_gen_q = value[31:0];
            dptf_pkg::REG_RATE_NUMERATOR:    num_q        = value[31:0];
            dptf_pkg::REG_RATE_DENOMINATOR:  den_q        = value[31:0];
            default: ;
        endcase
    endtask

    task automatic load_anchor(input logic [63:0] ap, input logic [63:0] af,
                               input logic [63:0] fq, input logic [31:0] ag,
                               input logic [31:0] rn, input logic [31:0] rd);
        write_reg(dptf_pkg::REG_ANCHOR_POSITION, ap);
        write_reg(dptf_pkg::REG_ANCHOR_FRAME, af);
        write_reg(dptf_pkg::REG_CLOCK_FREQUENCY, fq);
        write_reg(dptf_pkg::REG_ANCHOR_GENERATION, {$urandom, ag});
        write_reg(dptf_pkg::REG_RATE_NUMERATOR, {$urandom, rn});
        write_reg(dptf_pkg::REG_RATE_DENOMINATOR, {$urandom, rd});
    endtask

    // Waits until every outstanding result has been taken.
    task automatic drain();
        while (expected_frames.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // Offers one request and records its prediction when it is accepted.
    task automatic send_sample(input logic [63:0] pos, input logic [31:0] gen);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid          <= 1'b1;
        sample_position   <= pos;
        sample_generation <= gen;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_frames.push_back(calc_timeline_frame(pos, gen));
        requests_sent++;
    endtask

    // Receiver: checks accepted results and stalls at random.
    always @(posedge clk)
    begin
        frame_result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            code_hits[status]++;
            if (expected_frames.size() == 0)
                report_mismatch("result with no request outstanding");
            else
            begin
                e = expected_frames.pop_front();
                if (status !== e.code)
                    report_mismatch($sformatf("status %0d, want %0d", status, e.code));
                if (frame_number !== e.frame)
                    report_mismatch($sformatf("frame %0d, want %0d", frame_number, e.frame));
            end
        end
        out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // Run time guard.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Directed table: typed results where they are plain, else predicted.
    task automatic add_row(input logic [63:0] ap, input logic [63:0] af,
                           input logic [63:0] fq, input logic [31:0] ag,
                           input logic [31:0] rn, input logic [31:0] rd,
                           input logic [63:0] pos, input logic [31:0] gen,
                           input logic typed, input logic [62:0] fr,
                           input logic [2:0] code);
        directed_row_t r;
        r = '{ap, af, fq, ag, rn, rd, pos, gen, typed, fr, code};
        directed_rows.push_back(r);
    endtask

    initial
    begin
        directed_row_t row;
        frame_result_t want;
        logic [63:0]   ap, af, fq, delta;
        logic [31:0]   ag, rn, rd, gen;
        int            mode, count;

        rst_n              = 1'b0;
        cfg_write          <= 1'b0;
        cfg_index          <= '0;
        cfg_data           <= '0;
        in_valid           <= 1'b0;
        sample_position    <= '0;
        sample_generation  <= '0;
        out_stall          <= 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        mismatches         = 0;
        requests_sent      = 0;
        results_seen       = 0;
        cycles             = 0;
        anchor_pos_q       = 64'd0;
        anchor_frm_q       = 64'd0;
        freq_q             = 64'd48000;
        anchor_gen_q       = 32'd0;
        num_q              = 32'd30;
        den_q              = 32'd1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Reset values first, then extremes and each status in priority order.
        add_row(0, 0, 48000, 0, 30, 1, 0, 0, 1'b1, 63'd0, dptf_pkg::ST_OK);
        add_row(0, 0, 48000, 0, 30, 1, 48000, 0, 1'b1, 63'd30, dptf_pkg::ST_OK);
        add_row(0, 0, 48000, 0, 0, 1, 5, 0, 1'b1, 63'd0, dptf_pkg::ST_BAD_RATE);
        add_row(0, 0, 48000, 0, 30, 0, 5, 0, 1'b1, 63'd0, dptf_pkg::ST_BAD_RATE);
        add_row(0, FRAME_MIN, 0, 1, 0, 0, 0, 2, 1'b1, 63'd0, dptf_pkg::ST_BAD_RATE);
        add_row(0, 0, 0, 0, 30, 1, 5, 0, 1'b1, 63'd0, dptf_pkg::ST_BAD_FREQ);
        add_row(5, U64_MAX, 0, 1, 30, 1, 0, 2, 1'b1, 63'd0, dptf_pkg::ST_BAD_FREQ);
        add_row(0, U64_MAX, 48000, 0, 30, 1, 5, 0, 1'b1, 63'd0, dptf_pkg::ST_BAD_ANCHOR);
        add_row(5, FRAME_MIN, 48000, 1, 30, 1, 0, 2, 1'b1, 63'd0, dptf_pkg::ST_BAD_ANCHOR);
        add_row(0, 0, 48000, 0, 30, 1, 5, U32_MAX, 1'b1, 63'd0, dptf_pkg::ST_STALE);
        add_row(U64_MAX, 0, 48000, U32_MAX, 30, 1, 0, 0, 1'b1, 63'd0, dptf_pkg::ST_STALE);
        add_row(U64_MAX, 0, 48000, U32_MAX, 30, 1, U64_MAX - 1, U32_MAX, 1'b1, 63'd0,
                dptf_pkg::ST_BACKWARDS);
        add_row(U64_MAX, FRAME_MAX, 48000, 0, 30, 1, U64_MAX, 0, 1'b1, FRAME_MAX[62:0],
                dptf_pkg::ST_OK);
        add_row(0, FRAME_MAX, 48000, 0, 30, 1, 48000, 0, 1'b1, 63'd0,
                dptf_pkg::ST_OVERFLOW);
        add_row(0, 0, U64_MAX, 0, 1, U32_MAX, 1, 0, 1'b1, 63'd0, dptf_pkg::ST_OVERFLOW);
        add_row(0, 0, 1, 0, U32_MAX, 1, U64_MAX, 0, 1'b1, 63'd0, dptf_pkg::ST_OVERFLOW);
        add_row(0, 0, U64_MAX, U32_MAX, 30, 1, U64_MAX, U32_MAX, 1'b0, 63'd0,
                dptf_pkg::ST_OK);
        add_row(0, 0, 44100, 7, 30000, 1001, 123456789, 7, 1'b0, 63'd0, dptf_pkg::ST_OK);
        add_row(1000, 12345, 96000, 3, U32_MAX, U32_MAX, 64'hDEAD_BEEF_0000, 3, 1'b0,
                63'd0, dptf_pkg::ST_OK);
        add_row(0, 64'h0000_FFFF_FFFF_FFFF, 1, 9, 24, 1, 64'h0FFF_FFFF, 9, 1'b0, 63'd0,
                dptf_pkg::ST_OK);

        // Spare indexes must leave the register file alone.
        write_reg(REG_SPARE_LO, U64_MAX);
        write_reg(REG_SPARE_HI, 64'd0);
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (i > 0)
                load_anchor(row.anchor_pos, row.anchor_frm, row.freq, row.anchor_gen,
                            row.num, row.den);
            if (row.typed)
            begin
                want = calc_timeline_frame(row.pos, row.gen);
                want.frame = row.frame;
                want.code  = row.code;
                send_sample(row.pos, row.gen);
                expected_frames[expected_frames.size() - 1] = want;
            end
            else
                send_sample(row.pos, row.gen);
            in_valid <= 1'b0;
            drain();
        end

        // Random phases: each picks an idling pattern and a fresh anchor.
        for (int p = 0; p < N_PHASES; p++)
        begin
            mode = p % 4;
            sender_idle_pct    = (mode == 1) ? 82 : (mode == 3) ? 27 : 0;
            receiver_stall_pct = (mode == 2) ? 82 : (mode == 3) ? 27 : 0;
            ap = ($urandom_range(3) == 0) ? {$urandom, $urandom} : {32'd0, $urandom};
            af = ($urandom_range(4) == 0) ? FRAME_MAX - {32'd0, $urandom_range(100000)}
                                          : {32'd0, $urandom_range(1048575)};
            if (p == 5)
                af = {$urandom | 32'h8000_0000, $urandom};
            case ($urandom_range(5))
                0: fq = 64'd44100;
                1: fq = 64'd96000;
                2: fq = {32'd0, $urandom_range(1, 200000)};
                3: fq = 64'd48000;
                4: fq = {$urandom_range(1, 3), $urandom};
                default: fq = 64'd192000;
            endcase
            if (p == 7)
                fq = {$urandom, $urandom};
            if (p == 9)
                fq = 64'd0;
            ag = $urandom;
            rn = ($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 240);
            rd = ($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 1001);
            if (p == 11)
                rn = 32'd0;
            if (p == 13)
                rd = 32'd0;
            load_anchor(ap, af, fq, ag, rn, rd);
            count = (p == 7) ? 12 : 52;
            for (int k = 0; k < count; k++)
            begin
                // Mostly samples offset from the anchor under its generation; the rest noise.
                if ($urandom_range(4) != 0)
                begin
                    case ($urandom_range(3))
                        0: delta = {32'd0, $urandom};
                        1: delta = {48'd0, 16'($urandom)};
                        2: delta = {$urandom_range(255), $urandom};
                        default: delta = {$urandom, $urandom};
                    endcase
                    gen = ag;
                    send_sample(ap + delta, gen);
                end
                else
                begin
                    gen = ($urandom_range(1) == 0) ? $urandom : ag;
                    send_sample({$urandom, $urandom}, gen);
                end
            end
            in_valid <= 1'b0;
            drain();
        end

        repeat (50) @(posedge clk);
        $display("Sent %0d requests, checked %0d results over %0d anchor phases.",
                 requests_sent, results_seen, N_PHASES);
        $display("Status counts ok/rate/freq/anchor/stale/back/ovf: %0d %0d %0d %0d %0d %0d %0d",
                 code_hits[0], code_hits[1], code_hits[2], code_hits[3], code_hits[4],
                 code_hits[5], code_hits[6]);
        if (mismatches == 0 && expected_frames.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### device_position_to_timeline_frame.f
hdl/dptf_pkg.sv
hdl/dptf_divider.sv
hdl/dptf_multiplier.sv
hdl/device_position_to_timeline_frame.sv
sim/device_position_to_timeline_frame_tb.sv
